// File: hdl/kdg_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kdg_pkg
// Shared widths, phase codes, register indexes and reset values for the
// knob dial gesture detector.
// ----------------------------------------------------------------------------
package kdg_pkg;

  localparam int LevelW = 17;
  localparam int TickW  = 16;
  localparam int CountW = 3;
  localparam int PhaseW = 2;
  localparam int CfgW   = 17;
  localparam int IdxW   = 2;

  typedef logic [LevelW-1:0] level_t;
  typedef logic [TickW-1:0]  tick_t;
  typedef logic [CountW-1:0] count_t;
  typedef logic [PhaseW-1:0] phase_t;

  localparam phase_t PH_WAIT = 2'd0;
  localparam phase_t PH_HIGH = 2'd1;
  localparam phase_t PH_GAP  = 2'd2;

  localparam logic [IdxW-1:0] REG_THRESHOLD = 2'd0;
  localparam logic [IdxW-1:0] REG_MIN_INT   = 2'd1;
  localparam logic [IdxW-1:0] REG_MAX_INT   = 2'd2;
  localparam logic [IdxW-1:0] REG_DIALS     = 2'd3;

  localparam level_t THRESHOLD_RST = 17'd3277;  // about 0.05 in 1.16
  localparam tick_t  MIN_INT_RST   = 16'd200;
  localparam tick_t  MAX_INT_RST   = 16'd1000;
  localparam count_t DIALS_RST     = 3'd3;
  localparam tick_t  TICK_MAX      = '1;

endpackage

// File: hdl/knob_dial_gesture_detector.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// knob_dial_gesture_detector
// Detects a sequence of timed knob dials in a stream of knob samples.
// ----------------------------------------------------------------------------
// Usage:
//   knob channel: one knob_level sample per request, taken when knob_valid
//   is high and knob_stall is low. Each request yields exactly one result.
//   result channel: detected, dial_count and phase, taken when result_valid
//   is high and result_stall is low.
//   The result of a sample is registered and shown from the cycle after it
//   is taken. Throughput is one sample per cycle while the result channel
//   does not stall; the gesture state and the result register both update
//   in the accepting cycle.
//   A single result register sits between the channels. When it is full and
//   the receiver stalls, knob_stall rises and the sample waits; a new sample
//   is taken in the same cycle the pending result is taken.
//   cfg_write writes register cfg_index (0 threshold, 1 min interval,
//   2 max interval, 3 dials needed) from cfg_data; write only when idle.
//   Reset (rst, synchronous) restores register defaults, returns to the
//   waiting-for-long-low phase with counters cleared, and empties the
//   result register.
// ----------------------------------------------------------------------------
module knob_dial_gesture_detector
  import kdg_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_write,
  input  logic [IdxW-1:0]     cfg_index,
  input  logic [CfgW-1:0]     cfg_data,
  input  logic                knob_valid,
  output logic                knob_stall,
  input  logic [LevelW-1:0]   knob_level,
  output logic                result_valid,
  input  logic                result_stall,
  output logic                detected,
  output logic [CountW-1:0]   dial_count,
  output logic [PhaseW-1:0]   phase
);

  level_t knob_threshold;
  tick_t  min_interval_ms;
  tick_t  max_interval_ms;
  count_t dials_needed;

  phase_t phase_reg, phase_reg_next;
  tick_t  interval_ticks, interval_ticks_next;
  count_t dial_counter, dial_counter_next;

  logic   accept;
  logic   high;
  logic   in_window;
  tick_t  ticks_up;
  count_t count_inc;
  logic   det_next;
  count_t shown_next;

  assign knob_stall = result_valid & result_stall;
  assign accept     = knob_valid & ~knob_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      knob_threshold  <= THRESHOLD_RST;
      min_interval_ms <= MIN_INT_RST;
      max_interval_ms <= MAX_INT_RST;
      dials_needed    <= DIALS_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_THRESHOLD: knob_threshold  <= cfg_data;
        REG_MIN_INT:   min_interval_ms <= cfg_data[TickW-1:0];
        REG_MAX_INT:   max_interval_ms <= cfg_data[TickW-1:0];
        REG_DIALS:     dials_needed    <= cfg_data[CountW-1:0];
        default: ;
      endcase
    end
  end

  assign high      = (knob_level >= knob_threshold);
  assign in_window = (interval_ticks >= min_interval_ms) &&
                     (interval_ticks <= max_interval_ms);
  assign ticks_up  = (interval_ticks == TICK_MAX) ? TICK_MAX
                                                  : interval_ticks + 1'b1;
  assign count_inc = dial_counter + 1'b1;

  always_comb begin
    phase_reg_next      = phase_reg;
    interval_ticks_next = interval_ticks;
    dial_counter_next   = dial_counter;
    det_next            = 1'b0;
    shown_next          = dial_counter;
    case (phase_reg)
      PH_HIGH: begin
        if (high) begin
          interval_ticks_next = ticks_up;
        end else if (!in_window) begin
          phase_reg_next      = PH_WAIT;
          interval_ticks_next = 16'd1;
          dial_counter_next   = '0;
          shown_next          = '0;
        end else begin
          interval_ticks_next = 16'd1;
          shown_next          = count_inc;
          if (count_inc >= dials_needed) begin
            det_next          = 1'b1;
            phase_reg_next    = PH_WAIT;
            dial_counter_next = '0;
          end else begin
            phase_reg_next    = PH_GAP;
            dial_counter_next = count_inc;
          end
        end
      end
      PH_GAP: begin
        if (!high) begin
          interval_ticks_next = ticks_up;
        end else if (in_window) begin
          phase_reg_next      = PH_HIGH;
          interval_ticks_next = 16'd1;
        end else begin
          phase_reg_next      = PH_WAIT;
          interval_ticks_next = '0;
          dial_counter_next   = '0;
          shown_next          = '0;
        end
      end
      default: begin
        // waiting for a long low; the unused code lands here too
        phase_reg_next = PH_WAIT;
        if (!high) begin
          interval_ticks_next = ticks_up;
        end else if (interval_ticks >= min_interval_ms) begin
          phase_reg_next      = PH_HIGH;
          interval_ticks_next = 16'd1;
          dial_counter_next   = '0;
          shown_next          = '0;
        end else begin
          interval_ticks_next = '0;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_reg      <= PH_WAIT;
      interval_ticks <= '0;
      dial_counter   <= '0;
      result_valid   <= 1'b0;
    end else begin
      if (accept) begin
        phase_reg      <= phase_reg_next;
        interval_ticks <= interval_ticks_next;
        dial_counter   <= dial_counter_next;
        result_valid   <= 1'b1;
      end else if (!result_stall) begin
        result_valid   <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      detected   <= det_next;
      dial_count <= shown_next;
      phase      <= phase_reg_next;
    end
  end

endmodule

// File: hdl/kdg_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kdg_checker
// Port-level checks for the knob dial gesture detector, bound to the top.
// ----------------------------------------------------------------------------
module kdg_checker
  import kdg_pkg::*;
(
  input logic              clk,
  input logic              rst,
  input logic              knob_valid,
  input logic              knob_stall,
  input logic              result_valid,
  input logic              result_stall,
  input logic              detected,
  input logic [CountW-1:0] dial_count,
  input logic [PhaseW-1:0] phase
);

  // a completed gesture always restarts the search
  assert property (@(posedge clk) disable iff (rst)
    result_valid && detected |-> phase == PH_WAIT)
    else $error("detected without return to wait phase");

  // no dials are carried while waiting, except on the completing tick
  assert property (@(posedge clk) disable iff (rst)
    result_valid && phase == PH_WAIT && !detected |-> dial_count == '0)
    else $error("dial count kept in wait phase");

  // every accepted request produces a result next cycle
  assert property (@(posedge clk) disable iff (rst)
    knob_valid && !knob_stall |=> result_valid)
    else $error("accepted request without result");

  assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=>
      result_valid && $stable(detected) && $stable(dial_count) && $stable(phase))
    else $error("stalled result changed");

endmodule

bind knob_dial_gesture_detector kdg_checker u_kdg_checker (
  .clk          (clk),
  .rst          (rst),
  .knob_valid   (knob_valid),
  .knob_stall   (knob_stall),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .detected     (detected),
  .dial_count   (dial_count),
  .phase        (phase)
);

// File: dv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for knob_dial_gesture_detector. Knob samples stream
// through the request channel with random gaps and random result stalls. A
// cycle model of the gesture logic predicts every result, and results are
// checked in order as they leave the block. Directed runs hit the window
// limits, threshold edges and zero dials. Random phases then send
// well-formed gestures with noise under several register settings.
// ----------------------------------------------------------------------------
module tb;
  import kdg_pkg::*;

  localparam int WatchdogLimit = 1000;
  localparam int RandomSamples = 450;
  localparam int RandomPhases  = 5;
  localparam int SettleCycles  = 4;

  typedef struct packed {
    logic   det;
    count_t cnt;
    phase_t ph;
  } gesture_out_t;

  logic            clk          = 1'b0;
  logic            rst          = 1'b1;
  logic            cfg_write    = 1'b0;
  logic [IdxW-1:0] cfg_index    = '0;
  logic [CfgW-1:0] cfg_data     = '0;
  logic            knob_valid   = 1'b0;
  logic            knob_stall;
  level_t          knob_level   = '0;
  logic            result_valid;
  logic            result_stall = 1'b0;
  logic            detected;
  count_t          dial_count;
  phase_t          phase;

  // register copies
  level_t thr_cfg   = THRESHOLD_RST;
  tick_t  min_cfg   = MIN_INT_RST;
  tick_t  max_cfg   = MAX_INT_RST;
  count_t dials_cfg = DIALS_RST;

  // gesture state copy
  phase_t g_phase = PH_WAIT;
  tick_t  g_ticks = '0;
  count_t g_dials = '0;

  level_t       sample_q[$];
  gesture_out_t gesture_q[$];

  logic steady       = 1'b0;
  int   errors       = 0;
  int   samples_in   = 0;
  int   results_out  = 0;
  int   detections   = 0;
  int   aborts       = 0;
  int   quiet_cycles = 0;

  knob_dial_gesture_detector u_dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .knob_valid   (knob_valid),
    .knob_stall   (knob_stall),
    .knob_level   (knob_level),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .detected     (detected),
    .dial_count   (dial_count),
    .phase        (phase)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  function automatic tick_t tick_up(tick_t t);
    return (t == TICK_MAX) ? t : t + 1'b1;
  endfunction

  function automatic logic run_fits(tick_t t);
    return (t >= min_cfg) && (t <= max_cfg);
  endfunction

  // one tick of the gesture logic
  function automatic gesture_out_t gesture_step(level_t lvl);
    gesture_out_t r;
    logic         hi;
    hi    = (lvl >= thr_cfg);
    r.det = 1'b0;
    case (g_phase)
      PH_HIGH: begin
        if (hi) begin
          g_ticks = tick_up(g_ticks);
        end else if (!run_fits(g_ticks)) begin
          g_phase = PH_WAIT;
          g_ticks = 16'd1;
          g_dials = '0;
          aborts++;
        end else begin
          g_dials = g_dials + 1'b1;
          g_ticks = 16'd1;
          if (g_dials >= dials_cfg) begin
            r.det   = 1'b1;
            g_phase = PH_WAIT;
          end else begin
            g_phase = PH_GAP;
          end
        end
      end
      PH_GAP: begin
        if (!hi) begin
          g_ticks = tick_up(g_ticks);
        end else if (run_fits(g_ticks)) begin
          g_phase = PH_HIGH;
          g_ticks = 16'd1;
        end else begin
          g_phase = PH_WAIT;
          g_ticks = '0;
          g_dials = '0;
          aborts++;
        end
      end
      default: begin
        g_phase = PH_WAIT;
        if (!hi) begin
          g_ticks = tick_up(g_ticks);
        end else if (g_ticks >= min_cfg) begin
          g_phase = PH_HIGH;
          g_ticks = 16'd1;
          g_dials = '0;
        end else begin
          g_ticks = '0;
        end
      end
    endcase
    r.cnt = g_dials;
    r.ph  = g_phase;
    if (r.det) g_dials = '0;
    return r;
  endfunction

  // sample on one side of the threshold, leaning on the edges now and then
  function automatic level_t pick_level(logic hi);
    if (hi) begin
      case ($urandom_range(7, 0))
        0:       return thr_cfg;
        1:       return 17'd65536;
        default: return level_t'($urandom_range(65536, thr_cfg));
      endcase
    end else begin
      case ($urandom_range(7, 0))
        0:       return thr_cfg - 1'b1;
        1:       return '0;
        default: return level_t'($urandom_range(thr_cfg - 1, 0));
      endcase
    end
  endfunction

  task automatic push_run(logic hi, int n);
    repeat (n) sample_q.push_back(pick_level(hi));
  endtask

  function automatic int run_len(logic fits);
    int bot;
    int top;
    bot = (min_cfg == 0) ? 1 : min_cfg;
    top = max_cfg;
    if (bot > top) return $urandom_range(8, 1);  // nothing fits anyway
    if (fits) return $urandom_range(top, bot);
    if (bot > 1 && $urandom_range(1, 0) == 1) return bot - 1;
    return top + 1 + $urandom_range(2, 0);
  endfunction

  task automatic push_gesture();
    int rounds;
    rounds = (dials_cfg == 0) ? 1 : dials_cfg;
    if ($urandom_range(9, 0) == 0 && min_cfg > 1)
      push_run(1'b0, $urandom_range(min_cfg - 1, 1));
    else
      push_run(1'b0, min_cfg + $urandom_range(3, 1));
    for (int i = 0; i < rounds; i++) begin
      push_run(1'b1, run_len($urandom_range(9, 0) != 0));
      if (i < rounds - 1) push_run(1'b0, run_len($urandom_range(9, 0) != 0));
    end
    if ($urandom_range(9, 0) == 0)
      repeat ($urandom_range(6, 1)) sample_q.push_back(level_t'($urandom_range(65536, 0)));
  endtask

  // wait until every request is out and every result is back
  task automatic drain();
    while (sample_q.size() != 0 || knob_valid || gesture_q.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic write_reg(logic [IdxW-1:0] idx, logic [CfgW-1:0] val);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
  endtask

  task automatic set_config(level_t thr, tick_t mn, tick_t mx, count_t dn);
    drain();
    write_reg(REG_THRESHOLD, CfgW'(thr));
    write_reg(REG_MIN_INT, CfgW'(mn));
    write_reg(REG_MAX_INT, CfgW'(mx));
    write_reg(REG_DIALS, CfgW'(dn));
    @(posedge clk);
    cfg_write <= 1'b0;
    thr_cfg   = thr;
    min_cfg   = mn;
    max_cfg   = mx;
    dials_cfg = dn;
  endtask

  task automatic random_phase(tick_t mn, tick_t mx, count_t dn, logic hi_edge);
    level_t thr;
    thr = hi_edge ? level_t'(17'd65536) : level_t'($urandom_range(65536, 1));
    set_config(thr, mn, mx, dn);
    while (sample_q.size() < RandomSamples / RandomPhases) push_gesture();
  endtask

  // request driver
  always @(posedge clk) begin
    if (rst) begin
      knob_valid <= 1'b0;
    end else begin
      if (knob_valid && !knob_stall) begin
        gesture_q.push_back(gesture_step(knob_level));
        samples_in++;
      end
      if (!knob_valid || !knob_stall) begin
        if (sample_q.size() > 0 && (steady || $urandom_range(99, 0) >= 8)) begin
          knob_valid <= 1'b1;
          knob_level <= sample_q.pop_front();
        end else begin
          knob_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    gesture_out_t want;
    if (rst) begin
      result_stall <= 1'b0;
    end else begin
      if (result_valid && !result_stall) begin
        results_out++;
        if (gesture_q.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("unexpected result %0d: det %0b count %0d phase %0d",
                     results_out, detected, dial_count, phase);
        end else begin
          want = gesture_q.pop_front();
          if (detected !== want.det || dial_count !== want.cnt || phase !== want.ph) begin
            errors++;
            if (errors <= 10)
              $display({"mismatch on result %0d: expected det %0b count %0d phase %0d,",
                        " got det %0b count %0d phase %0d"}, results_out, want.det,
                       want.cnt, want.ph, detected, dial_count, phase);
          end
          if (want.det) detections++;
        end
      end
      result_stall <= !steady && ($urandom_range(99, 0) < 8);
    end
  end

  // watchdog on handshake progress
  always @(posedge clk) begin
    if (rst || (knob_valid && !knob_stall) || (result_valid && !result_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WatchdogLimit) begin
      $display("watchdog: nothing moved for %0d cycles", WatchdogLimit);
      $display("tb: failure");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // reset settings: a lead-in one short of the minimum, then a dial right
    // at the minimum, ended by a sample just under the threshold
    push_run(1'b0, 199);
    sample_q.push_back(THRESHOLD_RST);
    push_run(1'b0, 200);
    push_run(1'b1, 200);
    sample_q.push_back(THRESHOLD_RST - 1'b1);

    // narrow window: runs at both limits, then an over-long dial that aborts
    set_config(THRESHOLD_RST, 16'd2, 16'd4, 3'd3);
    push_run(1'b0, 2);
    push_run(1'b1, 2);
    push_run(1'b0, 4);
    push_run(1'b1, 4);
    push_run(1'b0, 2);
    push_run(1'b1, 2);
    push_run(1'b0, 2);
    push_run(1'b1, 5);
    push_run(1'b0, 1);

    // full-scale threshold, zero dials needed: first good dial completes
    set_config(17'd65536, 16'd1, 16'd2, 3'd0);
    sample_q.push_back(17'd65535);
    repeat (3) sample_q.push_back(17'd65536);
    sample_q.push_back(17'd0);
    sample_q.push_back(17'd65536);
    sample_q.push_back(17'd0);

    // zero threshold: every sample is high
    set_config(17'd0, 16'd0, 16'd65535, 3'd7);
    sample_q.push_back(17'd0);
    sample_q.push_back(17'd1);
    sample_q.push_back(17'd65535);
    sample_q.push_back(17'd65536);

    drain();
    steady <= 1'b1;
    random_phase(16'd2, 16'd5, 3'd3, 1'b0);
    drain();
    steady <= 1'b0;
    random_phase(16'd1, 16'd4, 3'd7, 1'b0);
    random_phase(16'd0, 16'd3, 3'd0, 1'b0);
    random_phase(16'd3, 16'd0, 3'd2, 1'b0);  // window empty
    random_phase(16'd2, 16'd6, 3'd4, 1'b1);
    drain();

    $display("run covered %0d knob samples and %0d results, %0d gestures detected",
             samples_in, results_out, detections);
    $display("%0d runs rejected out of window, %0d mismatches", aborts, errors);
    if (errors == 0 && gesture_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
